### rtl/lsps_pkg.sv
// shared types, constants and helpers for the light-seeking pid steering block
package lsps_pkg;

  localparam int unsigned PHOTO_W    = 10;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned ERR_W      = 11;
  localparam int unsigned DELTA_W    = 12;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned WIDE_W     = 41;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 8'd1;
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 8'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 8'd1;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 10'd50;
  localparam logic [DUTY_W-1:0] FULL_DUTY_RST = 8'd250;
  localparam logic [DUTY_W-1:0] SLOW_DUTY_RST = 8'd100;

  localparam logic signed [SUM_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_THRESHOLD = 3'd3,
    CFG_FULL_DUTY = 3'd4,
    CFG_SLOW_DUTY = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TURN_STRAIGHT = 2'd0,
    TURN_LEFT     = 2'd1,
    TURN_RIGHT    = 2'd2
  } turn_e;

  typedef struct packed {
    logic [PHOTO_W-1:0] photo_a;
    logic [PHOTO_W-1:0] photo_b;
    logic [PHOTO_W-1:0] photo_c;
    logic [PHOTO_W-1:0] photo_d;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       motor_one_duty;
    logic [DUTY_W-1:0]       motor_two_duty;
    turn_e                   turn_kind;
    logic                    pid_applied;
    logic signed [SUM_W-1:0] correction;
  } out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [THR_W-1:0]  turn_threshold;
    logic [DUTY_W-1:0] full_duty;
    logic [DUTY_W-1:0] slow_duty;
  } cfg_t;

  typedef struct packed {
    turn_e                   kind;
    logic [DUTY_W-1:0]       duty_one;
    logic [DUTY_W-1:0]       duty_two;
    logic                    run_pid;
    logic signed [ERR_W-1:0] err;
  } steer_t;

  typedef struct packed {
    steer_t                    steer;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   esum;
  } stage_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [SUM_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > WIDE_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < WIDE_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/light_seeking_pid_steering.sv
// top level: config registers, input/stage/result registers and handshakes
// data path: input register, then stage register, then result register
// throughput: one transaction per cycle while out_ready_i does not stall the output; the pid state loop
//   (sum add and clamp) is combinational in the stage after the input register
// each stage advances when the one after it is empty or advancing
// reset: asynchronous active low; clears valids, pid state and loads register defaults
module light_seeking_pid_steering (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lsps_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lsps_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  lsps_pkg::cfg_t   cfg_q, cfg_d;
  lsps_pkg::in_t    in_q;
  lsps_pkg::stage_t stage_q, stage_d;
  lsps_pkg::out_t   out_q, out_d;
  lsps_pkg::steer_t steer;
  logic signed [lsps_pkg::SUM_W-1:0]   stage_esum;
  logic signed [lsps_pkg::DELTA_W-1:0] stage_delta;
  logic             in_valid_q, stage_valid_q, out_valid_q;
  logic             in_en, stage_en, out_en, pid_upd;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (lsps_pkg::cfg_idx_e'(cfg_index_i))
        lsps_pkg::CFG_GAIN_P:    cfg_d.gain_p         = cfg_data_i[7:0];
        lsps_pkg::CFG_GAIN_I:    cfg_d.gain_i         = cfg_data_i[7:0];
        lsps_pkg::CFG_GAIN_D:    cfg_d.gain_d         = cfg_data_i[7:0];
        lsps_pkg::CFG_THRESHOLD: cfg_d.turn_threshold = cfg_data_i;
        lsps_pkg::CFG_FULL_DUTY: cfg_d.full_duty      = cfg_data_i[7:0];
        lsps_pkg::CFG_SLOW_DUTY: cfg_d.slow_duty      = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= lsps_pkg::GAIN_P_RST;
      cfg_q.gain_i         <= lsps_pkg::GAIN_I_RST;
      cfg_q.gain_d         <= lsps_pkg::GAIN_D_RST;
      cfg_q.turn_threshold <= lsps_pkg::THRESHOLD_RST;
      cfg_q.full_duty      <= lsps_pkg::FULL_DUTY_RST;
      cfg_q.slow_duty      <= lsps_pkg::SLOW_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline enables
  assign out_en     = !out_valid_q || out_ready_i;
  assign stage_en   = !stage_valid_q || out_en;
  assign in_en      = !in_valid_q || stage_en;
  assign in_ready_o = in_en;
  assign pid_upd    = stage_en && in_valid_q && steer.run_pid;

  lsps_steer u_steer (
    .photo_i (in_q),
    .cfg_i   (cfg_q),
    .steer_o (steer)
  );

  lsps_pid_state u_pid_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (pid_upd),
    .err_i   (steer.err),
    .esum_o  (stage_esum),
    .delta_o (stage_delta)
  );

  assign stage_d = '{steer: steer, delta: stage_delta, esum: stage_esum};

  lsps_pid_calc u_pid_calc (
    .stage_i (stage_q),
    .cfg_i   (cfg_q),
    .out_o   (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_en) begin
        in_valid_q <= in_valid_i;
      end
      if (stage_en) begin
        stage_valid_q <= in_valid_q;
      end
      if (out_en) begin
        out_valid_q <= stage_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (stage_en && in_valid_q) begin
      stage_q <= stage_d;
    end
    if (out_en && stage_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pid_needs_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.pid_applied
                    || out_data_o.turn_kind != lsps_pkg::TURN_STRAIGHT)
    else $error("pid applied while going straight");

  a_zero_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pid_applied |-> out_data_o.correction == '0)
    else $error("correction set without pid");

  a_full_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pid_applied
      |-> out_data_o.motor_one_duty == cfg_q.full_duty
          || out_data_o.motor_two_duty == cfg_q.full_duty)
    else $error("pid result has no full-duty motor");

  a_no_stage_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && !out_en |=> stage_valid_q)
    else $error("stage transaction dropped under stall");

endmodule

### rtl/lsps_steer.sv
// turn decision from the sensor means, base duties and pid trigger
module lsps_steer (
  input  lsps_pkg::in_t    photo_i,
  input  lsps_pkg::cfg_t   cfg_i,
  output lsps_pkg::steer_t steer_o
);

  logic [lsps_pkg::PHOTO_W:0]          sum_ac, sum_bd;
  logic [lsps_pkg::PHOTO_W-1:0]        mean_ac, mean_bd;
  logic signed [lsps_pkg::PHOTO_W+1:0] diff_ac, diff_bd, thr_s;
  logic                                go_left, go_right;

  assign sum_ac  = {1'b0, photo_i.photo_a} + {1'b0, photo_i.photo_c};
  assign sum_bd  = {1'b0, photo_i.photo_b} + {1'b0, photo_i.photo_d};
  assign mean_ac = sum_ac[lsps_pkg::PHOTO_W:1];
  assign mean_bd = sum_bd[lsps_pkg::PHOTO_W:1];

  assign diff_ac  = $signed({2'b00, mean_ac}) - $signed({2'b00, mean_bd});
  assign diff_bd  = $signed({2'b00, mean_bd}) - $signed({2'b00, mean_ac});
  assign thr_s    = $signed({2'b00, cfg_i.turn_threshold});
  assign go_left  = diff_ac > thr_s;
  assign go_right = diff_bd > thr_s;

  always_comb begin
    steer_o.err = $signed({1'b0, photo_i.photo_a}) - $signed({1'b0, photo_i.photo_b});
    if (go_left) begin
      steer_o.kind     = lsps_pkg::TURN_LEFT;
      steer_o.duty_one = cfg_i.slow_duty;
      steer_o.duty_two = cfg_i.full_duty;
      steer_o.run_pid  = photo_i.photo_a > photo_i.photo_c;
    end else if (go_right) begin
      steer_o.kind     = lsps_pkg::TURN_RIGHT;
      steer_o.duty_one = cfg_i.full_duty;
      steer_o.duty_two = cfg_i.slow_duty;
      steer_o.run_pid  = photo_i.photo_b > photo_i.photo_d;
    end else begin
      steer_o.kind     = lsps_pkg::TURN_STRAIGHT;
      steer_o.duty_one = cfg_i.full_duty;
      steer_o.duty_two = cfg_i.full_duty;
      steer_o.run_pid  = 1'b0;
    end
  end

endmodule

### rtl/lsps_pid_state.sv
// pid integrator and previous-error registers
module lsps_pid_state (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  upd_i,
  input  logic signed [lsps_pkg::ERR_W-1:0]     err_i,
  output logic signed [lsps_pkg::SUM_W-1:0]     esum_o,
  output logic signed [lsps_pkg::DELTA_W-1:0]   delta_o
);

  logic signed [lsps_pkg::SUM_W-1:0]  esum_q, esum_d;
  logic signed [lsps_pkg::ERR_W-1:0]  prev_q, prev_d;
  logic signed [lsps_pkg::WIDE_W-1:0] esum_wide;

  assign esum_wide = lsps_pkg::WIDE_W'(esum_q) + lsps_pkg::WIDE_W'(err_i);
  assign esum_o    = lsps_pkg::sat_s32(esum_wide);
  assign delta_o   = lsps_pkg::DELTA_W'(err_i) - lsps_pkg::DELTA_W'(prev_q);

  assign esum_d = upd_i ? esum_o : esum_q;
  assign prev_d = upd_i ? err_i : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      prev_q <= '0;
    end else begin
      esum_q <= esum_d;
      prev_q <= prev_d;
    end
  end

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(esum_q) && $stable(prev_q))
    else $error("pid state moved without an update");

  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i |=> prev_q == $past(err_i))
    else $error("previous error not loaded");

  a_sum_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && esum_wide <= lsps_pkg::WIDE_W'(lsps_pkg::S32_MAX)
          && esum_wide >= lsps_pkg::WIDE_W'(lsps_pkg::S32_MIN)
      |=> lsps_pkg::WIDE_W'(esum_q) == $past(esum_wide))
    else $error("error sum step wrong inside range");

endmodule

### rtl/lsps_pid_calc.sv
// weighted pid sum, saturation and duty reduction
module lsps_pid_calc (
  input  lsps_pkg::stage_t stage_i,
  input  lsps_pkg::cfg_t   cfg_i,
  output lsps_pkg::out_t   out_o
);

  logic signed [lsps_pkg::GAIN_W:0]   gp_s, gi_s, gd_s;
  logic signed [lsps_pkg::WIDE_W-1:0] prod_p, prod_i, prod_d, total;
  logic signed [lsps_pkg::SUM_W-1:0]  corr;
  logic [lsps_pkg::SUM_W-1:0]         corr_u, mag;
  logic [lsps_pkg::DUTY_W-1:0]        reduced;
  logic                               corr_pos;

  assign gp_s = $signed({1'b0, cfg_i.gain_p});
  assign gi_s = $signed({1'b0, cfg_i.gain_i});
  assign gd_s = $signed({1'b0, cfg_i.gain_d});

  assign prod_p = gp_s * $signed(stage_i.steer.err);
  assign prod_i = gi_s * $signed(stage_i.esum);
  assign prod_d = gd_s * $signed(stage_i.delta);
  assign total  = prod_p + prod_i + prod_d;
  assign corr   = lsps_pkg::sat_s32(total);

  // magnitude fits 32 unsigned bits, also for the most negative value
  assign corr_u   = corr;
  assign mag      = corr[lsps_pkg::SUM_W-1] ? (~corr_u + 32'd1) : corr_u;
  assign reduced  = (mag > {24'd0, cfg_i.full_duty}) ? '0 : cfg_i.full_duty - mag[7:0];
  assign corr_pos = !corr[lsps_pkg::SUM_W-1] && (corr != '0);

  always_comb begin
    out_o.turn_kind   = stage_i.steer.kind;
    out_o.pid_applied = stage_i.steer.run_pid;
    if (stage_i.steer.run_pid) begin
      out_o.correction     = corr;
      out_o.motor_one_duty = corr_pos ? reduced : cfg_i.full_duty;
      out_o.motor_two_duty = corr_pos ? cfg_i.full_duty : reduced;
    end else begin
      out_o.correction     = '0;
      out_o.motor_one_duty = stage_i.steer.duty_one;
      out_o.motor_two_duty = stage_i.steer.duty_two;
    end
  end

endmodule

### bench/light_seeking_pid_steering_test.sv
// self-checking testbench for the light-seeking pid steering block
module light_seeking_pid_steering_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 400_000;
  localparam int SAMPLES_PER_RUN = 460;
  localparam int RISE_BURST      = 20;
  localparam int FALL_BURST      = 40;
  // indexes past the last register, the block must drop these writes
  localparam logic [lsps_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [lsps_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  class steering_scoreboard;
    logic [lsps_pkg::GAIN_W-1:0] gain_p, gain_i, gain_d;
    logic [lsps_pkg::THR_W-1:0]  turn_thr;
    logic [lsps_pkg::DUTY_W-1:0] full_duty, slow_duty;
    int                          err_sum, prev_err;
    lsps_pkg::out_t              due_commands[$];
    int                          errors;

    function new();
      gain_p    = lsps_pkg::GAIN_P_RST;
      gain_i    = lsps_pkg::GAIN_I_RST;
      gain_d    = lsps_pkg::GAIN_D_RST;
      turn_thr  = lsps_pkg::THRESHOLD_RST;
      full_duty = lsps_pkg::FULL_DUTY_RST;
      slow_duty = lsps_pkg::SLOW_DUTY_RST;
      err_sum   = 0;
      prev_err  = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                            logic [lsps_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lsps_pkg::CFG_GAIN_P:    gain_p    = data[lsps_pkg::GAIN_W-1:0];
        lsps_pkg::CFG_GAIN_I:    gain_i    = data[lsps_pkg::GAIN_W-1:0];
        lsps_pkg::CFG_GAIN_D:    gain_d    = data[lsps_pkg::GAIN_W-1:0];
        lsps_pkg::CFG_THRESHOLD: turn_thr  = data[lsps_pkg::THR_W-1:0];
        lsps_pkg::CFG_FULL_DUTY: full_duty = data[lsps_pkg::DUTY_W-1:0];
        lsps_pkg::CFG_SLOW_DUTY: slow_duty = data[lsps_pkg::DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(lsps_pkg::S32_MAX)) return longint'(lsps_pkg::S32_MAX);
      if (v < longint'(lsps_pkg::S32_MIN)) return longint'(lsps_pkg::S32_MIN);
      return v;
    endfunction

    function logic [lsps_pkg::DUTY_W-1:0] trimmed_duty(logic [lsps_pkg::DUTY_W-1:0] base,
                                                       longint corr);
      longint rest;
      rest = longint'(base) - ((corr < 0) ? -corr : corr);
      return (rest < 0) ? '0 : lsps_pkg::DUTY_W'(rest);
    endfunction

    function lsps_pkg::out_t predict_steering(lsps_pkg::in_t x);
      int             a, b, c, d, err, delta;
      longint         corr;
      lsps_pkg::out_t r;
      a = x.photo_a;
      b = x.photo_b;
      c = x.photo_c;
      d = x.photo_d;
      r = '0;
      if ((a + c) / 2 - (b + d) / 2 > int'(turn_thr)) begin
        r.turn_kind      = lsps_pkg::TURN_LEFT;
        r.motor_one_duty = slow_duty;
        r.motor_two_duty = full_duty;
        r.pid_applied    = (a > c);
      end else if ((b + d) / 2 - (a + c) / 2 > int'(turn_thr)) begin
        r.turn_kind      = lsps_pkg::TURN_RIGHT;
        r.motor_one_duty = full_duty;
        r.motor_two_duty = slow_duty;
        r.pid_applied    = (b > d);
      end else begin
        r.turn_kind      = lsps_pkg::TURN_STRAIGHT;
        r.motor_one_duty = full_duty;
        r.motor_two_duty = full_duty;
      end
      if (r.pid_applied) begin
        err     = a - b;
        delta   = err - prev_err;
        err_sum = int'(clamp32(longint'(err_sum) + err));
        corr    = clamp32(longint'(gain_p) * err + longint'(gain_i) * err_sum
                          + longint'(gain_d) * delta);
        prev_err = err;
        // zero correction falls on the motor two side
        if (corr > 0) begin
          r.motor_one_duty = trimmed_duty(full_duty, corr);
          r.motor_two_duty = full_duty;
        end else begin
          r.motor_one_duty = full_duty;
          r.motor_two_duty = trimmed_duty(full_duty, corr);
        end
        r.correction = lsps_pkg::SUM_W'(corr);
      end
      return r;
    endfunction

    function void note_sample(lsps_pkg::in_t x);
      due_commands.push_back(predict_steering(x));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic signed [63:0] got, logic signed [63:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_command(lsps_pkg::out_t got);
      lsps_pkg::out_t want;
      if (due_commands.size() == 0) begin
        report("steering transaction with nothing expected");
      end else begin
        want = due_commands.pop_front();
        compare_field("motor_one_duty", got.motor_one_duty, want.motor_one_duty);
        compare_field("motor_two_duty", got.motor_two_duty, want.motor_two_duty);
        compare_field("turn_kind", got.turn_kind, want.turn_kind);
        compare_field("pid_applied", got.pid_applied, want.pid_applied);
        compare_field("correction", got.correction, want.correction);
      end
    endtask
  endclass

  typedef struct packed {
    logic [lsps_pkg::CFG_IDX_W-1:0]  idx;
    logic [lsps_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  lsps_pkg::in_t                   in_data_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  lsps_pkg::out_t                  out_data_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [lsps_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [lsps_pkg::CFG_DATA_W-1:0] cfg_data_i;

  steering_scoreboard board = new();
  reg_write_t         reg_writes[$];
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 cycle_count = 0;

  light_seeking_pid_steering dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) board.note_sample(in_data_i);
      if (out_valid_o && out_ready_i) board.check_command(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // called at a clock edge; leaves valid high after the transaction
  task send_sample(lsps_pkg::in_t x);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait out every pending steering command
  task settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.due_commands.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function void queue_reg(logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                          logic [lsps_pkg::CFG_DATA_W-1:0] data);
    reg_writes.push_back('{idx, data});
  endfunction

  task program_regs();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function void queue_random_settings();
    queue_reg(lsps_pkg::CFG_GAIN_P, {2'($urandom), 8'($urandom)});
    queue_reg(lsps_pkg::CFG_GAIN_I, {2'($urandom), 8'($urandom_range(0, 7))});
    queue_reg(lsps_pkg::CFG_GAIN_D, {2'($urandom), 8'($urandom)});
    queue_reg(lsps_pkg::CFG_THRESHOLD, 10'($urandom_range(0, 120)));
    queue_reg(lsps_pkg::CFG_FULL_DUTY, {2'($urandom), 8'($urandom_range(128, 255))});
    queue_reg(lsps_pkg::CFG_SLOW_DUTY, {2'($urandom), 8'($urandom)});
  endfunction

  // mostly samples shaped to turn with the pid engaged, the rest plain noise
  function lsps_pkg::in_t random_sample();
    lsps_pkg::in_t x;
    int            pick;
    pick = $urandom_range(0, 99);
    x.photo_a = 10'($urandom);
    x.photo_b = 10'($urandom);
    x.photo_c = 10'($urandom);
    x.photo_d = 10'($urandom);
    if (pick < 35) begin
      x.photo_a = 10'($urandom_range(400, 1023));
      x.photo_c = 10'($urandom_range(0, x.photo_a - 1));
      x.photo_b = 10'($urandom_range(0, 500));
      x.photo_d = 10'($urandom_range(0, 400));
    end else if (pick < 70) begin
      x.photo_b = 10'($urandom_range(400, 1023));
      x.photo_d = 10'($urandom_range(0, x.photo_b - 1));
      x.photo_a = 10'($urandom_range(0, 500));
      x.photo_c = 10'($urandom_range(0, 400));
    end
    return x;
  endfunction

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 28;
    rx_idle_pct = 75;

    // reset settings: turn decisions, threshold edge, duty floor, zero correction
    send_sample('{10'd0, 10'd0, 10'd0, 10'd0});
    send_sample('{10'd1023, 10'd1023, 10'd1023, 10'd1023});
    send_sample('{10'd1023, 10'd0, 10'd0, 10'd0});
    send_sample('{10'd0, 10'd0, 10'd1023, 10'd0});
    send_sample('{10'd0, 10'd1023, 10'd0, 10'd0});
    send_sample('{10'd0, 10'd0, 10'd0, 10'd1023});
    send_sample('{10'd600, 10'd600, 10'd400, 10'd0});
    send_sample('{10'd600, 10'd600, 10'd400, 10'd0});
    send_sample('{10'd100, 10'd50, 10'd100, 10'd50});
    send_sample('{10'd101, 10'd50, 10'd101, 10'd50});
    send_sample('{10'd101, 10'd50, 10'd100, 10'd50});
    send_sample('{10'd300, 10'd290, 10'd100, 10'd0});
    send_sample('{10'd0, 10'd700, 10'd0, 10'd699});
    settle();

    // everything at zero, plus writes to unused indexes
    queue_reg(lsps_pkg::CFG_GAIN_P, '0);
    queue_reg(lsps_pkg::CFG_GAIN_I, '0);
    queue_reg(lsps_pkg::CFG_GAIN_D, '0);
    queue_reg(lsps_pkg::CFG_THRESHOLD, '0);
    queue_reg(lsps_pkg::CFG_FULL_DUTY, '0);
    queue_reg(lsps_pkg::CFG_SLOW_DUTY, '0);
    queue_reg(CFG_SPARE_LO, '1);
    queue_reg(CFG_SPARE_HI, '1);
    program_regs();
    send_sample('{10'd3, 10'd0, 10'd0, 10'd0});
    send_sample('{10'd0, 10'd0, 10'd0, 10'd0});
    send_sample('{10'd0, 10'd3, 10'd0, 10'd0});
    settle();

    // everything at the top, upper data bits set on the narrow registers
    queue_reg(lsps_pkg::CFG_GAIN_P, '1);
    queue_reg(lsps_pkg::CFG_GAIN_I, '1);
    queue_reg(lsps_pkg::CFG_GAIN_D, '1);
    queue_reg(lsps_pkg::CFG_THRESHOLD, '1);
    queue_reg(lsps_pkg::CFG_FULL_DUTY, '1);
    queue_reg(lsps_pkg::CFG_SLOW_DUTY, '1);
    program_regs();
    send_sample('{10'd1023, 10'd0, 10'd1023, 10'd0});
    send_sample('{10'd0, 10'd1023, 10'd0, 10'd1023});

    for (int run = 0; run < 3; run++) begin
      settle();
      queue_random_settings();
      program_regs();
      tx_idle_pct = (run == 0) ? 28 : (run == 1) ? 75 : 0;
      rx_idle_pct = (run == 0) ? 75 : (run == 1) ? 28 : 0;
      for (int n = 0; n < SAMPLES_PER_RUN; n++) begin
        if (run == 0 && n == 150) settle();
        send_sample(random_sample());
      end
    end
    settle();

    // largest gains: push the error sum up, then back down through zero
    queue_reg(lsps_pkg::CFG_GAIN_P, 10'd255);
    queue_reg(lsps_pkg::CFG_GAIN_I, 10'd255);
    queue_reg(lsps_pkg::CFG_GAIN_D, 10'd255);
    queue_reg(lsps_pkg::CFG_THRESHOLD, 10'd0);
    queue_reg(lsps_pkg::CFG_FULL_DUTY, 10'd255);
    queue_reg(lsps_pkg::CFG_SLOW_DUTY, 10'd0);
    program_regs();
    repeat (RISE_BURST) send_sample('{10'd1023, 10'd0, 10'd0, 10'd0});
    repeat (FALL_BURST) send_sample('{10'd0, 10'd1023, 10'd0, 10'd0});
    settle();
    repeat (10) @(posedge clk_i);

    if (board.errors == 0 && board.due_commands.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
